>>> sv/rbsi_pkg.sv
// rbsi_pkg: shared widths, register indexes, sideband types and helpers for the
// ray/box slab intersection pipeline; no dependencies
package rbsi_pkg;

  localparam int W       = 32;                // coordinate and distance width
  localparam int SCALE_W = 31;                // distance scale width
  localparam int FRAC    = 16;                // fractional bits of Q16.16
  localparam int DIFF_W  = W + 1;             // bound minus origin
  localparam int NUM_W   = DIFF_W + FRAC;     // dividend magnitude width
  localparam int QW      = NUM_W + 1;         // signed quotient width
  localparam int PROD_W  = 2 * W;             // distance times scale
  localparam int DIV_LAT = NUM_W;             // one quotient bit per stage
  localparam int TOTAL_LAT = 1 + DIV_LAT + 2 + 2;

  localparam logic [W-1:0] FAR_LIMIT_DEF = 32'h7fff_ffff;
  localparam logic [W-1:0] BOX_MIN_RST   = 32'h0000_0000;
  localparam logic [W-1:0] BOX_MAX_RST   = 32'h0001_0000;

  typedef enum logic [2:0] {
    REG_MIN_X = 3'd0,
    REG_MAX_X = 3'd1,
    REG_MIN_Y = 3'd2,
    REG_MAX_Y = 3'd3,
    REG_MIN_Z = 3'd4,
    REG_MAX_Z = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic zero;    // direction is zero on this axis
    logic inslab;  // origin lies between the planes
    logic s1;      // entry quotient is negative
    logic s2;      // exit quotient is negative
  } axis_info_t;

  typedef struct packed {
    axis_info_t [2:0]   ax;
    logic [SCALE_W-1:0] scale;
  } side_t;

  function automatic logic signed [W-1:0] sat_q(input logic signed [QW-1:0] v);
    logic signed [QW-1:0] hi_lim;
    logic signed [QW-1:0] lo_lim;
    hi_lim = QW'($signed({1'b0, {(W-1){1'b1}}}));
    lo_lim = -hi_lim - QW'(1);
    if (v > hi_lim)      sat_q = {1'b0, {(W-1){1'b1}}};
    else if (v < lo_lim) sat_q = {1'b1, {(W-1){1'b0}}};
    else                 sat_q = v[W-1:0];
  endfunction

endpackage

>>> sv/rbsi_prep.sv
// rbsi_prep: first stage, slab plane pick, differences, magnitudes and signs
// depends on rbsi_pkg
module rbsi_prep (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_vld,
  input  logic signed [rbsi_pkg::W-1:0]       o      [3],
  input  logic signed [rbsi_pkg::W-1:0]       d      [3],
  input  logic signed [rbsi_pkg::W-1:0]       lo     [3],
  input  logic signed [rbsi_pkg::W-1:0]       hi     [3],
  input  logic        [rbsi_pkg::SCALE_W-1:0] scale,
  output logic                                out_vld,
  output logic        [rbsi_pkg::NUM_W-1:0]   num    [6],
  output logic        [rbsi_pkg::W-1:0]       den    [3],
  output rbsi_pkg::side_t                     side
);

  logic [rbsi_pkg::NUM_W-1:0] num_next [6];
  logic [rbsi_pkg::W-1:0]     den_next [3];
  rbsi_pkg::side_t            side_next;

  always_comb begin
    logic                              neg;
    logic signed [rbsi_pkg::W-1:0]     b1;
    logic signed [rbsi_pkg::W-1:0]     b2;
    logic signed [rbsi_pkg::DIFF_W-1:0] n1;
    logic signed [rbsi_pkg::DIFF_W-1:0] n2;
    logic        [rbsi_pkg::DIFF_W-1:0] m1;
    logic        [rbsi_pkg::DIFF_W-1:0] m2;
    side_next.scale = scale;
    for (int a = 0; a < 3; a++) begin
      neg = d[a][rbsi_pkg::W-1];
      b1  = neg ? hi[a] : lo[a];
      b2  = neg ? lo[a] : hi[a];
      n1  = {b1[rbsi_pkg::W-1], b1} - {o[a][rbsi_pkg::W-1], o[a]};
      n2  = {b2[rbsi_pkg::W-1], b2} - {o[a][rbsi_pkg::W-1], o[a]};
      m1  = n1[rbsi_pkg::DIFF_W-1] ? -n1 : n1;
      m2  = n2[rbsi_pkg::DIFF_W-1] ? -n2 : n2;
      num_next[2*a]   = {m1, {rbsi_pkg::FRAC{1'b0}}};
      num_next[2*a+1] = {m2, {rbsi_pkg::FRAC{1'b0}}};
      den_next[a]     = neg ? -d[a] : d[a];
      side_next.ax[a].zero   = (d[a] == '0);
      side_next.ax[a].inslab = (o[a] >= lo[a]) && (o[a] <= hi[a]);
      side_next.ax[a].s1     = n1[rbsi_pkg::DIFF_W-1] ^ neg;
      side_next.ax[a].s2     = n2[rbsi_pkg::DIFF_W-1] ^ neg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    num  <= num_next;
    den  <= den_next;
    side <= side_next;
  end

endmodule

>>> sv/rbsi_div.sv
// rbsi_div: pipelined unsigned restoring divider, one quotient bit per stage
// depends on rbsi_pkg
module rbsi_div (
  input  logic                         clk,
  input  logic [rbsi_pkg::NUM_W-1:0]   num,
  input  logic [rbsi_pkg::W-1:0]       den,
  output logic [rbsi_pkg::NUM_W-1:0]   quo
);

  localparam int N  = rbsi_pkg::NUM_W;
  localparam int DW = rbsi_pkg::W;

  logic [DW-1:0] rem_r [N];
  logic [N-1:0]  nq_r  [N];
  logic [DW-1:0] den_r [N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic [DW-1:0] rem_in;
    logic [N-1:0]  nq_in;
    logic [DW-1:0] den_in;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    if (i == 0) begin : g_first
      assign rem_in = '0;
      assign nq_in  = num;
      assign den_in = den;
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign nq_in  = nq_r[i-1];
      assign den_in = den_r[i-1];
    end

    assign trial = {rem_in, nq_in[N-1]};
    assign diff  = trial - {1'b0, den_in};
    assign ge    = (trial >= {1'b0, den_in});

    always_ff @(posedge clk) begin
      rem_r[i] <= ge ? diff[DW-1:0] : trial[DW-1:0];
      nq_r[i]  <= {nq_in[N-2:0], ge};
      den_r[i] <= den_in;
    end
  end

  assign quo = nq_r[N-1];

endmodule

>>> sv/rbsi_post.sv
// rbsi_post: signed slab intervals, interval intersection, hit and saturation
// depends on rbsi_pkg
module rbsi_post #(
  parameter logic [rbsi_pkg::W-1:0] FAR_LIMIT = rbsi_pkg::FAR_LIMIT_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_vld,
  input  logic        [rbsi_pkg::NUM_W-1:0]   q      [6],
  input  rbsi_pkg::side_t                     side,
  output logic                                out_vld,
  output logic                                hit,
  output logic signed [rbsi_pkg::W-1:0]       t_near,
  output logic signed [rbsi_pkg::W-1:0]       t_far,
  output logic        [rbsi_pkg::SCALE_W-1:0] scale
);

  localparam int QW = rbsi_pkg::QW;

  logic signed [QW-1:0] t1_next [3];
  logic signed [QW-1:0] t2_next [3];
  logic                 ok_next;
  logic signed [QW-1:0] t1 [3];
  logic signed [QW-1:0] t2 [3];
  logic                 ok;
  logic                 vld1;
  logic [rbsi_pkg::SCALE_W-1:0] scale1;

  always_comb begin
    logic signed [QW-1:0] m1;
    logic signed [QW-1:0] m2;
    ok_next = 1'b1;
    for (int a = 0; a < 3; a++) begin
      m1 = $signed({1'b0, q[2*a]});
      m2 = $signed({1'b0, q[2*a+1]});
      if (side.ax[a].zero) begin
        t1_next[a] = '0;
        t2_next[a] = QW'($signed({1'b0, FAR_LIMIT}));
        if (!side.ax[a].inslab) ok_next = 1'b0;
      end else begin
        t1_next[a] = side.ax[a].s1 ? -m1 : m1;
        t2_next[a] = side.ax[a].s2 ? -m2 : m2;
      end
    end
  end

  always_ff @(posedge clk) begin
    t1     <= t1_next;
    t2     <= t2_next;
    ok     <= ok_next;
    scale1 <= side.scale;
  end

  // entry is the latest plane crossing, exit the earliest
  logic signed [QW-1:0] tn;
  logic signed [QW-1:0] tf;
  logic                 hit_next;

  always_comb begin
    tn = (t1[0] > t1[1]) ? t1[0] : t1[1];
    if (t1[2] > tn) tn = t1[2];
    tf = (t2[0] < t2[1]) ? t2[0] : t2[1];
    if (t2[2] < tf) tf = t2[2];
    hit_next = ok && (tn <= tf);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1    <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      vld1    <= in_vld;
      out_vld <= vld1;
    end
  end

  always_ff @(posedge clk) begin
    hit    <= hit_next;
    t_near <= hit_next ? rbsi_pkg::sat_q(tn) : '0;
    t_far  <= hit_next ? rbsi_pkg::sat_q(tf) : '0;
    scale  <= scale1;
  end

endmodule

>>> sv/rbsi_scale.sv
// rbsi_scale: multiplies both distances by the scale, floors by 2^16, saturates
// depends on rbsi_pkg
module rbsi_scale (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_vld,
  input  logic                                in_hit,
  input  logic signed [rbsi_pkg::W-1:0]       in_near,
  input  logic signed [rbsi_pkg::W-1:0]       in_far,
  input  logic        [rbsi_pkg::SCALE_W-1:0] scale,
  output logic                                out_vld,
  output logic                                hit,
  output logic signed [rbsi_pkg::W-1:0]       t_near,
  output logic signed [rbsi_pkg::W-1:0]       t_far
);

  localparam int PW = rbsi_pkg::PROD_W;
  localparam int SW = PW - rbsi_pkg::FRAC;

  logic signed [PW-1:0] p_near;
  logic signed [PW-1:0] p_far;
  logic                 hit1;
  logic                 vld1;

  // 32 by 32 signed products, operands sign extended to the product width
  always_ff @(posedge clk) begin
    p_near <= PW'(in_near) * PW'($signed({1'b0, scale}));
    p_far  <= PW'(in_far) * PW'($signed({1'b0, scale}));
    hit1   <= in_hit;
  end

  function automatic logic signed [rbsi_pkg::W-1:0] sat_s(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] hi_lim;
    logic signed [SW-1:0] lo_lim;
    hi_lim = SW'($signed({1'b0, {(rbsi_pkg::W-1){1'b1}}}));
    lo_lim = -hi_lim - SW'(1);
    if (v > hi_lim)      sat_s = {1'b0, {(rbsi_pkg::W-1){1'b1}}};
    else if (v < lo_lim) sat_s = {1'b1, {(rbsi_pkg::W-1){1'b0}}};
    else                 sat_s = v[rbsi_pkg::W-1:0];
  endfunction

  // arithmetic shift rounds toward minus infinity
  always_ff @(posedge clk) begin
    t_near <= sat_s(p_near[PW-1:rbsi_pkg::FRAC]);
    t_far  <= sat_s(p_far[PW-1:rbsi_pkg::FRAC]);
    hit    <= hit1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1    <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      vld1    <= in_vld;
      out_vld <= vld1;
    end
  end

endmodule

>>> sv/ray_box_slab_intersect_top.sv
// ray_box_slab_intersect_top: ray versus box slab test, fully pipelined
// depends on rbsi_pkg, rbsi_prep, rbsi_div, rbsi_post, rbsi_scale
// from start to done a ray passes the prep, divider, interval and scale stages
// throughput: one ray per cycle, busy is never raised; the receiver cannot stall
// reset: synchronous rst clears all valid bits and loads the unit box [0,1]^3
// the 49-stage divider (one quotient bit per stage) sets the latency
module ray_box_slab_intersect_top #(
  parameter logic [rbsi_pkg::W-1:0] FAR_LIMIT = rbsi_pkg::FAR_LIMIT_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // ray beat
  input  logic                                start,
  output logic                                busy,
  input  logic signed [rbsi_pkg::W-1:0]       origin_x,
  input  logic signed [rbsi_pkg::W-1:0]       origin_y,
  input  logic signed [rbsi_pkg::W-1:0]       origin_z,
  input  logic signed [rbsi_pkg::W-1:0]       direction_x,
  input  logic signed [rbsi_pkg::W-1:0]       direction_y,
  input  logic signed [rbsi_pkg::W-1:0]       direction_z,
  input  logic        [rbsi_pkg::SCALE_W-1:0] distance_scale,
  // result beat
  output logic                                done,
  output logic                                hit,
  output logic signed [rbsi_pkg::W-1:0]       t_near,
  output logic signed [rbsi_pkg::W-1:0]       t_far,
  // box register writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic        [2:0]                   cfg_index,
  input  logic        [rbsi_pkg::W-1:0]       cfg_data
);

  // no back pressure anywhere: a new ray enters every cycle
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // box registers, lower and upper plane per axis
  logic signed [rbsi_pkg::W-1:0] box_lo [3];
  logic signed [rbsi_pkg::W-1:0] box_hi [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < 3; a++) begin
        box_lo[a] <= rbsi_pkg::BOX_MIN_RST;
        box_hi[a] <= rbsi_pkg::BOX_MAX_RST;
      end
    end else if (cfg_valid && cfg_ready) begin
      case (rbsi_pkg::reg_idx_t'(cfg_index))
        rbsi_pkg::REG_MIN_X: box_lo[0] <= cfg_data;
        rbsi_pkg::REG_MAX_X: box_hi[0] <= cfg_data;
        rbsi_pkg::REG_MIN_Y: box_lo[1] <= cfg_data;
        rbsi_pkg::REG_MAX_Y: box_hi[1] <= cfg_data;
        rbsi_pkg::REG_MIN_Z: box_lo[2] <= cfg_data;
        rbsi_pkg::REG_MAX_Z: box_hi[2] <= cfg_data;
        default: ;  // writes past the register list are dropped
      endcase
    end
  end

  logic signed [rbsi_pkg::W-1:0] org [3];
  logic signed [rbsi_pkg::W-1:0] dir [3];

  assign org[0] = origin_x;
  assign org[1] = origin_y;
  assign org[2] = origin_z;
  assign dir[0] = direction_x;
  assign dir[1] = direction_y;
  assign dir[2] = direction_z;

  // stage 1: plane selection, magnitudes and quotient signs
  logic                        prep_vld;
  logic [rbsi_pkg::NUM_W-1:0]  prep_num [6];
  logic [rbsi_pkg::W-1:0]      prep_den [3];
  rbsi_pkg::side_t             prep_side;

  rbsi_prep u_prep (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (start && !busy),
    .o       (org),
    .d       (dir),
    .lo      (box_lo),
    .hi      (box_hi),
    .scale   (distance_scale),
    .out_vld (prep_vld),
    .num     (prep_num),
    .den     (prep_den),
    .side    (prep_side)
  );

  // six dividers, entry and exit plane per axis
  logic [rbsi_pkg::NUM_W-1:0] quo [6];

  for (genvar j = 0; j < 6; j++) begin : g_div
    rbsi_div u_div (
      .clk (clk),
      .num (prep_num[j]),
      .den (prep_den[j/2]),
      .quo (quo[j])
    );
  end

  // valid bit and sideband ride alongside the divider stages
  logic            dly_vld  [rbsi_pkg::DIV_LAT];
  rbsi_pkg::side_t dly_side [rbsi_pkg::DIV_LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < rbsi_pkg::DIV_LAT; k++) dly_vld[k] <= 1'b0;
    end else begin
      dly_vld[0] <= prep_vld;
      for (int k = 1; k < rbsi_pkg::DIV_LAT; k++) dly_vld[k] <= dly_vld[k-1];
    end
  end

  always_ff @(posedge clk) begin
    dly_side[0] <= prep_side;
    for (int k = 1; k < rbsi_pkg::DIV_LAT; k++) dly_side[k] <= dly_side[k-1];
  end

  // interval intersection and hit decision
  logic                                post_vld;
  logic                                post_hit;
  logic signed [rbsi_pkg::W-1:0]       post_near;
  logic signed [rbsi_pkg::W-1:0]       post_far;
  logic        [rbsi_pkg::SCALE_W-1:0] post_scale;

  rbsi_post #(.FAR_LIMIT(FAR_LIMIT)) u_post (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (dly_vld[rbsi_pkg::DIV_LAT-1]),
    .q       (quo),
    .side    (dly_side[rbsi_pkg::DIV_LAT-1]),
    .out_vld (post_vld),
    .hit     (post_hit),
    .t_near  (post_near),
    .t_far   (post_far),
    .scale   (post_scale)
  );

  // distance scaling, misses carry zeros through
  rbsi_scale u_scale (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (post_vld),
    .in_hit  (post_hit),
    .in_near (post_near),
    .in_far  (post_far),
    .scale   (post_scale),
    .out_vld (done),
    .hit     (hit),
    .t_near  (t_near),
    .t_far   (t_far)
  );

endmodule

>>> sv/rbsi_chk.sv
// rbsi_chk: port-level checks on the slab intersection top level
// depends on rbsi_pkg and ray_box_slab_intersect_top (bound below)
module rbsi_chk #(
  parameter int LAT = rbsi_pkg::TOTAL_LAT
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic                          done,
  input logic                          hit,
  input logic signed [rbsi_pkg::W-1:0] t_near,
  input logic signed [rbsi_pkg::W-1:0] t_far
);

  // every result beat matches a ray beat a fixed latency earlier
  a_done_has_ray: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result beat without a ray");

  a_no_done_after_rst: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result beat right after reset");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !hit) |-> (t_near == '0) && (t_far == '0))
    else $error("miss with nonzero distances");

  a_hit_order: assert property (@(posedge clk) disable iff (rst)
    (done && hit) |-> (t_near <= t_far))
    else $error("hit with entry past exit");

endmodule

bind ray_box_slab_intersect_top rbsi_chk #(.LAT(rbsi_pkg::TOTAL_LAT)) u_rbsi_chk (.*);
